// ----- hdl/i2cswr_pkg.sv -----
// Package for the write-only I2C target: constants, codes, state and result types.
// Used by the core, cfg, rx and obuf files of the block; depends on nothing.

package i2cswr_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int OWN_ADDR_W  = 7;
    localparam int LIMIT_W     = 16;
    localparam int CMP_W       = (TIMER_WIDTH > LIMIT_W) ? TIMER_WIDTH : LIMIT_W;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [LIMIT_W-1:0]    TIMEOUT_RESET  = LIMIT_W'(124);
    localparam logic [OWN_ADDR_W-1:0] OWN_ADDR_RESET = '0;

    typedef enum logic [2:0] {
        EV_NONE        = 3'd0,
        EV_START_WRITE = 3'd1,
        EV_START_READ  = 3'd2,
        EV_DATA        = 3'd3,
        EV_STOP        = 3'd4,
        EV_TIMEOUT     = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        AM_NONE  = 2'd0,
        AM_WRITE = 2'd1,
        AM_DATA  = 2'd2,
        AM_READ  = 2'd3
    } t_ack_mode;

    typedef logic [3:0] t_phase;
    localparam t_phase PH_IDLE   = 4'd0;
    localparam t_phase PH_BIT1   = 4'd1;
    localparam t_phase PH_BIT7   = 4'd7;
    localparam t_phase PH_BIT8   = 4'd8;
    localparam t_phase PH_ACKDEC = 4'd9;
    localparam t_phase PH_ACKEND = 4'd10;

    // Register index, taken from paddr bit 2
    typedef enum logic {
        REG_OWN_ADDR = 1'b0,
        REG_TIMEOUT  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_phase                 bit_phase;
        logic [7:0]             shift_reg;
        t_ack_mode              ack_mode;
        logic                   data_phase;
        logic [TIMER_WIDTH-1:0] tick_count;
        logic                   sda_drive;
    } t_rx_state;

    typedef struct packed {
        logic       sda_pull_low;
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic       bus_active;
    } t_rx_result;

    function automatic t_rx_state f_idle_state();
        t_rx_state s;
        s.bit_phase  = PH_IDLE;
        s.shift_reg  = '0;
        s.ack_mode   = AM_NONE;
        s.data_phase = 1'b0;
        s.tick_count = '0;
        s.sda_drive  = 1'b0;
        return s;
    endfunction

endpackage

// ----- hdl/i2cswr_if.sv -----
// Handshake channels of the write-only I2C target: pin-sample items in, result items out.
// Depends on nothing.

interface i2cswr_in_if;
    logic valid;
    logic ready;
    logic scl;
    logic sda;
    logic accept_data;
    logic timer_tick;

    modport source (output valid, scl, sda, accept_data, timer_tick, input ready);
    modport sink   (input valid, scl, sda, accept_data, timer_tick, output ready);
endinterface

interface i2cswr_out_if;
    logic       valid;
    logic       ready;
    logic       sda_pull_low;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic       bus_active;

    modport source (output valid, sda_pull_low, event_res, data_byte, bus_active, input ready);
    modport sink   (input valid, sda_pull_low, event_res, data_byte, bus_active, output ready);
endinterface

// ----- hdl/i2c_slave_write_receiver_core.sv -----
// Write-only I2C target, 7-bit addressing: one pin-sample item in, one result item out.
// Depends on i2cswr_pkg, i2cswr_if, i2cswr_cfg, i2cswr_rx and i2cswr_obuf.

// One item carries one clock's sample of SCL and SDA plus the accept_data and timer_tick
// strobes; every item gives exactly one result, which is registered in the output buffer.
// The block takes an item every cycle: the protocol state is updated in a single pass
// at acceptance, and results go through a two-entry output buffer, so i_in.ready falls
// only when two results are waiting. Sustained rate is one item per clock as long as
// results are taken. Registers (APB, byte address 0: own address, 4: timeout limit)
// are to be written by the user only while no item is in flight; the block does not enforce it.

module i2c_slave_write_receiver_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    i2cswr_in_if.sink                         i_in,
    i2cswr_out_if.source                      o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [i2cswr_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [i2cswr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [i2cswr_pkg::CFG_DATA_W-1:0] prdata,
    output logic                              pready
);

    logic [i2cswr_pkg::OWN_ADDR_W-1:0] own_address;
    logic [i2cswr_pkg::LIMIT_W-1:0]    timeout_limit;
    logic                              in_accept;
    logic                              buf_ready;
    i2cswr_pkg::t_rx_result            step_result;
    i2cswr_pkg::t_rx_result            out_result;

    assign i_in.ready = buf_ready;
    assign in_accept  = i_in.valid & buf_ready;

    i2cswr_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_own_address   (own_address),
        .o_timeout_limit (timeout_limit)
    );

    i2cswr_rx u_rx (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_scl           (i_in.scl),
        .i_sda           (i_in.sda),
        .i_accept_data   (i_in.accept_data),
        .i_timer_tick    (i_in.timer_tick),
        .i_own_address   (own_address),
        .i_timeout_limit (timeout_limit),
        .o_result        (step_result)
    );

    i2cswr_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_result    (step_result),
        .o_ready     (buf_ready),
        .o_valid     (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_result    (out_result)
    );

    assign o_res.sda_pull_low = out_result.sda_pull_low;
    assign o_res.event_res    = out_result.event_res;
    assign o_res.data_byte    = out_result.data_byte;
    assign o_res.bus_active   = out_result.bus_active;

`ifndef SYNTH
    // input may only stall when a result is waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_res.valid)
        else $error("input stalled with empty output");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !o_res.valid) |=> o_res.valid)
        else $error("accepted item produced no result");

    // ACK drive only happens inside a transfer
    a_ack_in_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.sda_pull_low) |-> o_res.bus_active)
        else $error("SDA driven while bus idle");

    a_byte_only_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_res != i2cswr_pkg::EV_DATA) |-> (o_res.data_byte == 8'd0))
        else $error("data byte set without data event");
`endif

endmodule

// ----- hdl/i2cswr_cfg.sv -----
// APB-style register file: own address and timeout limit.
// Depends on i2cswr_pkg.

module i2cswr_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [i2cswr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [i2cswr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [i2cswr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                 pready,
    output logic [i2cswr_pkg::OWN_ADDR_W-1:0]    o_own_address,
    output logic [i2cswr_pkg::LIMIT_W-1:0]       o_timeout_limit
);

    logic [i2cswr_pkg::OWN_ADDR_W-1:0] r_own_address;
    logic [i2cswr_pkg::LIMIT_W-1:0]    r_timeout_limit;
    logic                              wr_en;
    i2cswr_pkg::t_reg_idx              reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = i2cswr_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address   <= i2cswr_pkg::OWN_ADDR_RESET;
            r_timeout_limit <= i2cswr_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                i2cswr_pkg::REG_OWN_ADDR: begin
                    r_own_address <= pwdata[i2cswr_pkg::OWN_ADDR_W-1:0];
                end
                i2cswr_pkg::REG_TIMEOUT: begin
                    r_timeout_limit <= pwdata[i2cswr_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            i2cswr_pkg::REG_OWN_ADDR:
                prdata = i2cswr_pkg::CFG_DATA_W'(r_own_address);
            i2cswr_pkg::REG_TIMEOUT:
                prdata = i2cswr_pkg::CFG_DATA_W'(r_timeout_limit);
            default:
                prdata = '0;
        endcase
    end

    assign o_own_address   = r_own_address;
    assign o_timeout_limit = r_timeout_limit;

endmodule

// ----- hdl/i2cswr_rx.sv -----
// Bus follower: line-edge detection, address/data shifting, ACK control and timeout.
// Holds the protocol state; depends on i2cswr_pkg.

module i2cswr_rx (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic                              i_scl,
    input  logic                              i_sda,
    input  logic                              i_accept_data,
    input  logic                              i_timer_tick,
    input  logic [i2cswr_pkg::OWN_ADDR_W-1:0] i_own_address,
    input  logic [i2cswr_pkg::LIMIT_W-1:0]    i_timeout_limit,
    output i2cswr_pkg::t_rx_result            o_result
);

    i2cswr_pkg::t_rx_state r_st;
    i2cswr_pkg::t_rx_state n_st;
    logic                  r_prev_scl;
    logic                  r_prev_sda;

    i2cswr_pkg::t_event            ev;
    logic [7:0]                    byte_out;
    logic                          timed_out;
    logic                          steady_high;
    logic                          rise;
    logic                          fall;
    logic [7:0]                    shifted;
    logic [i2cswr_pkg::CMP_W-1:0]  count_ext;
    logic [i2cswr_pkg::CMP_W-1:0]  limit_ext;

    assign steady_high = r_prev_scl & i_scl;
    assign rise        = ~r_prev_scl & i_scl;
    assign fall        = r_prev_scl & ~i_scl;
    assign count_ext   = i2cswr_pkg::CMP_W'(r_st.tick_count);
    assign limit_ext   = i2cswr_pkg::CMP_W'(i_timeout_limit);

    always_comb begin
        n_st      = r_st;
        ev        = i2cswr_pkg::EV_NONE;
        byte_out  = '0;
        timed_out = 1'b0;
        shifted   = {r_st.shift_reg[6:0], i_sda};

        // Unused phase codes fall back to idle
        if (r_st.bit_phase > i2cswr_pkg::PH_ACKEND) begin
            n_st = i2cswr_pkg::f_idle_state();
        end

        if (n_st.bit_phase != i2cswr_pkg::PH_IDLE && i_timer_tick) begin
            if (count_ext >= limit_ext || &r_st.tick_count) begin
                n_st      = i2cswr_pkg::f_idle_state();
                ev        = i2cswr_pkg::EV_TIMEOUT;
                timed_out = 1'b1;
            end else begin
                n_st.tick_count = r_st.tick_count + 1'b1;
            end
        end

        if (!timed_out) begin
            shifted = {n_st.shift_reg[6:0], i_sda};
            if (steady_high && r_prev_sda && !i_sda) begin
                // start or repeated start
                n_st           = i2cswr_pkg::f_idle_state();
                n_st.bit_phase = i2cswr_pkg::PH_BIT1;
            end else if (steady_high && !r_prev_sda && i_sda) begin
                if (n_st.bit_phase != i2cswr_pkg::PH_IDLE) begin
                    n_st = i2cswr_pkg::f_idle_state();
                    ev   = i2cswr_pkg::EV_STOP;
                end
            end else if (rise && n_st.bit_phase >= i2cswr_pkg::PH_BIT1
                         && n_st.bit_phase <= i2cswr_pkg::PH_BIT7) begin
                n_st.shift_reg = shifted;
                if (n_st.bit_phase == i2cswr_pkg::PH_BIT7 && !n_st.data_phase
                    && shifted != {1'b0, i_own_address}) begin
                    n_st = i2cswr_pkg::f_idle_state();
                end else begin
                    n_st.bit_phase = n_st.bit_phase + 1'b1;
                end
            end else if (rise && n_st.bit_phase == i2cswr_pkg::PH_BIT8) begin
                if (n_st.data_phase) begin
                    n_st.shift_reg = shifted;
                    n_st.ack_mode  = i2cswr_pkg::AM_DATA;
                end else if (i_sda) begin
                    n_st.ack_mode = i2cswr_pkg::AM_READ;
                    ev            = i2cswr_pkg::EV_START_READ;
                end else begin
                    n_st.ack_mode = i2cswr_pkg::AM_WRITE;
                    ev            = i2cswr_pkg::EV_START_WRITE;
                end
                n_st.bit_phase = i2cswr_pkg::PH_ACKDEC;
            end else if (fall && n_st.bit_phase == i2cswr_pkg::PH_ACKDEC) begin
                if (n_st.ack_mode == i2cswr_pkg::AM_WRITE) begin
                    n_st.sda_drive = 1'b1;
                    n_st.bit_phase = i2cswr_pkg::PH_ACKEND;
                end else if (n_st.ack_mode == i2cswr_pkg::AM_DATA) begin
                    ev             = i2cswr_pkg::EV_DATA;
                    byte_out       = n_st.shift_reg;
                    n_st.sda_drive = i_accept_data;
                    n_st.bit_phase = i2cswr_pkg::PH_ACKEND;
                end else begin
                    // reads are NAKed and dropped
                    n_st = i2cswr_pkg::f_idle_state();
                end
            end else if (fall && n_st.bit_phase == i2cswr_pkg::PH_ACKEND) begin
                n_st.sda_drive  = 1'b0;
                n_st.shift_reg  = '0;
                n_st.data_phase = 1'b1;
                n_st.bit_phase  = i2cswr_pkg::PH_BIT1;
            end
        end

        o_result.sda_pull_low = n_st.sda_drive;
        o_result.event_res    = ev;
        o_result.data_byte    = byte_out;
        o_result.bus_active   = (n_st.bit_phase != i2cswr_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= i2cswr_pkg::f_idle_state();
            r_prev_scl <= 1'b1;
            r_prev_sda <= 1'b1;
        end else if (i_accept) begin
            r_st       <= n_st;
            r_prev_scl <= i_scl;
            r_prev_sda <= i_sda;
        end
    end

endmodule

// ----- hdl/i2cswr_obuf.sv -----
// Two-entry result buffer: output register plus skid entry.
// Depends on i2cswr_pkg.

module i2cswr_obuf (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  i2cswr_pkg::t_rx_result i_result,
    output logic                   o_ready,
    output logic                   o_valid,
    input  logic                   i_out_ready,
    output i2cswr_pkg::t_rx_result o_result
);

    logic                   r_main_valid;
    logic                   r_skid_valid;
    i2cswr_pkg::t_rx_result r_main;
    i2cswr_pkg::t_rx_result r_skid;
    logic                   pop;

    assign pop      = r_main_valid & i_out_ready;
    assign o_ready  = ~r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // skid full: no push possible, refill main from skid
            if (pop) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

endmodule
